@@ rtl/apd_pkg.sv @@
package apd_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int ROW_W      = 12;
  localparam int HEIGHT_MAX = 4096;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_IMAGE_HEIGHT = 3'd4;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // predictor selected for one pixel
  typedef enum logic [1:0] {
    PRED_NONE = 2'd0,   // first pixel of the image
    PRED_LEFT = 2'd1,   // rest of top row
    PRED_UP   = 2'd2,   // left column
    PRED_AVG  = 2'd3    // interior
  } pred_t;

  // raster position flags of the next byte
  typedef struct packed {
    logic pad;
    logic row0;
    logic col0;
    logic last_col;
    logic last_row;
  } pos_t;

endpackage

@@ rtl/apd_ram.sv @@
module apd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/apd_raster.sv @@
module apd_raster #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [apd_pkg::CFG_W-1:0]     image_width,
  input  logic [apd_pkg::CFG_W-1:0]     image_height,
  input  logic                          adv,
  output logic [$clog2(MAX_WIDTH)-1:0]  col,
  output apd_pkg::pos_t                 pos
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (EW > apd_pkg::CFG_W) ? EW : apd_pkg::CFG_W;
  localparam int HW   = apd_pkg::CFG_W;
  localparam int RW   = apd_pkg::ROW_W;

  logic [AW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic            pad_r, pad_nxt;

  logic [CMPW-1:0] w_ext, w_sat;
  logic [EW-1:0]   w_eff, w_m1;
  logic [HW-1:0]   h_eff, h_m1;
  logic [AW-1:0]   col_c;
  logic [RW-1:0]   row_c;
  logic            last_col, last_row;

  always_comb begin
    w_ext = CMPW'(image_width);
    if (w_ext == '0) begin
      w_sat = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_sat = CMPW'(MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    w_eff = w_sat[EW-1:0];
    w_m1  = w_eff - EW'(1);

    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (image_height > HW'(apd_pkg::HEIGHT_MAX)) begin
      h_eff = HW'(apd_pkg::HEIGHT_MAX);
    end else begin
      h_eff = image_height;
    end
    h_m1 = h_eff - HW'(1);

    // restart position if the geometry shrank under it
    col_c    = (EW'(col_r) >= w_eff) ? '0 : col_r;
    row_c    = (HW'(row_r) >= h_eff) ? '0 : row_r;
    last_col = (EW'(col_c) == w_m1);
    last_row = (HW'(row_c) == h_m1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pad_nxt = pad_r;
    if (adv) begin
      if (pad_r) begin
        pad_nxt = 1'b0;
      end else if (last_col) begin
        col_nxt = '0;
        pad_nxt = w_eff[0];
        row_nxt = last_row ? '0 : row_c + RW'(1);
      end else begin
        col_nxt = col_c + AW'(1);
        row_nxt = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pad_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pad_r <= pad_nxt;
    end
  end

  assign col          = col_c;
  assign pos.pad      = pad_r;
  assign pos.row0     = (row_c == '0);
  assign pos.col0     = (col_c == '0);
  assign pos.last_col = last_col;
  assign pos.last_row = last_row;

endmodule

@@ rtl/alpha_predictive_decoder.sv @@
// Channel | Direction | Signals                                      | Transfer when
// --------+-----------+----------------------------------------------+----------------------
// in      | input     | in_valid, in_ready, in_residual_byte         | in_valid & in_ready
// out     | output    | out_valid, out_ready, out_alpha_value,       | out_valid & out_ready
//         |           | out_row_end, out_image_end                   |
// cfg     | input     | psel, penable, pwrite, paddr, pwdata,        | psel & penable &
//         |           | prdata, pready                               | pwrite & pready
//
// One byte per cycle sustained while out_ready stays high. A pixel's byte passes the byte
// register, then the result register, before the pixel is presented on out; the line buffer
// read issued at input transfer is used by the average and subtract while the byte is held.
// Padding bytes leave the byte register without waiting on out and produce no transfer on out.
// Reset (rst_n low, synchronous) returns to row 0, column 0 with 640 x 480; the line
// buffer is not cleared. A stalled out holds one result plus one byte; in_ready drops.
module alpha_predictive_decoder #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // residual byte stream
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [apd_pkg::PIX_W-1:0]      in_residual_byte,
  // decoded pixels
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [apd_pkg::PIX_W-1:0]      out_alpha_value,
  output logic                           out_row_end,
  output logic                           out_image_end,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apd_pkg::PADDR_W-1:0]    paddr,
  input  logic [apd_pkg::PDATA_W-1:0]    pwdata,
  output logic [apd_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = apd_pkg::PIX_W;
  localparam int CW = apd_pkg::CFG_W;

  // ---------------- configuration registers ----------------
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] height_r, height_nxt;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    prdata     = '0;
    unique case (paddr)
      apd_pkg::ADDR_IMAGE_WIDTH: begin
        prdata = apd_pkg::PDATA_W'(width_r);
        if (cfg_wr) width_nxt = pwdata[CW-1:0];
      end
      apd_pkg::ADDR_IMAGE_HEIGHT: begin
        prdata = apd_pkg::PDATA_W'(height_r);
        if (cfg_wr) height_nxt = pwdata[CW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= apd_pkg::IMAGE_WIDTH_RST;
      height_r <= apd_pkg::IMAGE_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // ---------------- raster position ----------------
  logic          in_xfer;
  logic [AW-1:0] pos_col;
  apd_pkg::pos_t pos;

  apd_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .adv          (in_xfer),
    .col          (pos_col),
    .pos          (pos)
  );

  // ---------------- byte register (stage A) ----------------
  logic                a_valid_r, a_valid_nxt;
  logic [PW-1:0]       a_byte_r;
  logic [AW-1:0]       a_col_r;
  logic                a_pad_r;
  apd_pkg::pred_t      a_pred_r;
  apd_pkg::pred_t      pred_c;
  logic                a_last_col_r;
  logic                a_last_row_r;
  logic                a_adv;        // stage A item leaves this cycle
  logic                pix_done;     // a real pixel completes this cycle

  assign a_adv    = a_valid_r && (a_pad_r || !out_valid || out_ready);
  assign pix_done = a_adv && !a_pad_r;
  assign in_ready = !a_valid_r || a_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (pos.row0 && pos.col0) begin
      pred_c = apd_pkg::PRED_NONE;
    end else if (pos.row0) begin
      pred_c = apd_pkg::PRED_LEFT;
    end else if (pos.col0) begin
      pred_c = apd_pkg::PRED_UP;
    end else begin
      pred_c = apd_pkg::PRED_AVG;
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_xfer) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_byte_r     <= in_residual_byte;
      a_col_r      <= pos_col;
      a_pad_r      <= pos.pad;
      a_pred_r     <= pred_c;
      a_last_col_r <= pos.last_col;
      a_last_row_r <= pos.last_row;
    end
  end

  // ---------------- line buffer ----------------
  logic [PW-1:0] ram_rdata;
  logic [PW-1:0] pix_v;
  logic          fwd_r;
  logic [PW-1:0] fwd_data_r;
  logic [PW-1:0] up_pix;

  apd_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (pix_done),
    .waddr (a_col_r),
    .wdata (pix_v),
    .re    (in_xfer),
    .raddr (pos_col),
    .rdata (ram_rdata)
  );

  // Width-1 images read the column being written in the same cycle: bypass it.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_r      <= pix_done && (a_col_r == pos_col);
      fwd_data_r <= pix_v;
    end
  end

  assign up_pix = fwd_r ? fwd_data_r : ram_rdata;

  // ---------------- prediction ----------------
  logic [PW-1:0] left_r;
  logic [PW:0]   pair_sum;

  assign pair_sum = {1'b0, left_r} + {1'b0, up_pix};

  always_comb begin
    unique case (a_pred_r)
      apd_pkg::PRED_NONE: pix_v = a_byte_r;
      apd_pkg::PRED_LEFT: pix_v = left_r - a_byte_r;
      apd_pkg::PRED_UP:   pix_v = up_pix - a_byte_r;
      apd_pkg::PRED_AVG:  pix_v = pair_sum[PW:1] - a_byte_r;
      default:            pix_v = a_byte_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (pix_done) begin
      left_r <= pix_v;
    end
  end

  // ---------------- result register ----------------
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_alpha_r;
  logic          out_row_end_r;
  logic          out_image_end_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pix_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_done) begin
      out_alpha_r     <= pix_v;
      out_row_end_r   <= a_last_col_r;
      out_image_end_r <= a_last_col_r && a_last_row_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alpha_value = out_alpha_r;
  assign out_row_end     = out_row_end_r;
  assign out_image_end   = out_image_end_r;

`ifndef NO_ASSERTIONS
  // the input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without a held result");

  // the last pixel of the image is also the last of its row
  a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_end) |-> out_row_end)
    else $error("image end without row end");

  // a padding byte never produces a result
  a_pad_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_pad_r && !out_valid) |=> !out_valid)
    else $error("padding byte produced a result");
`endif

endmodule

@@ sim/alpha_predictive_decoder_tb.sv @@
`timescale 1ns / 1ps

module alpha_predictive_decoder_tb;

  localparam int     LINE_MAX   = 4096;          // line buffer depth of the instance
  localparam longint TIMEOUT_NS = 64'd20_000_000; // far beyond the slowest legal run
  localparam int     RAND_BYTES = 1100;           // residual bytes in the random part

  // one decoded pixel as it leaves the block
  typedef struct packed {
    logic [apd_pkg::PIX_W-1:0] alpha;
    logic                      row_end;
    logic                      image_end;
  } pixel_t;

  typedef logic [apd_pkg::PIX_W-1:0] byte_q_t[$];

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN = 2'd0,   // always ready
    RX_COIN = 2'd1,   // ready half the time
    RX_SLOW = 2'd2,   // ready a quarter of the time
    RX_BEAT = 2'd3    // regular on/off beat
  } rx_mode_t;

  // Tracks the raster position, line buffer and left pixel of the decoder and
  // queues the pixel each residual byte should produce.
  class alpha_plane_tracker;
    logic [apd_pkg::CFG_W-1:0] width_reg;
    logic [apd_pkg::CFG_W-1:0] height_reg;
    int unsigned               col;
    int unsigned               row;
    bit                        pad_due;
    logic [apd_pkg::PIX_W-1:0] left_px;
    logic [apd_pkg::PIX_W-1:0] line_buf [LINE_MAX];
    bit                        line_seen [LINE_MAX];
    pixel_t                    pixels_due [$];
    int                        errors;
    int                        bytes_in;
    int                        pads_in;
    int                        pixels_out;
    int                        images_out;
    int                        pred_hits [4];

    function new();
      width_reg  = apd_pkg::IMAGE_WIDTH_RST;
      height_reg = apd_pkg::IMAGE_HEIGHT_RST;
      col        = 0;
      row        = 0;
      pad_due    = 0;
      left_px    = '0;
      errors     = 0;
      bytes_in   = 0;
      pads_in    = 0;
      pixels_out = 0;
      images_out = 0;
      foreach (pred_hits[i]) pred_hits[i] = 0;
      foreach (line_seen[i]) line_seen[i] = 0;
    endfunction

    // zero counts as one, anything above the limit saturates
    function int unsigned fit(logic [apd_pkg::CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return 32'(v);
    endfunction

    function void write_reg(logic [apd_pkg::PADDR_W-1:0] addr,
                            logic [apd_pkg::PDATA_W-1:0] data);
      case (addr)
        apd_pkg::ADDR_IMAGE_WIDTH:  width_reg  = data[apd_pkg::CFG_W-1:0];
        apd_pkg::ADDR_IMAGE_HEIGHT: height_reg = data[apd_pkg::CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // A new size must never lead to a line buffer read of an entry that was
    // never written. In the top row the columns left of the restart point are
    // read by the next row; below the top row every column is read.
    function bit size_is_safe(logic [apd_pkg::CFG_W-1:0] w,
                              logic [apd_pkg::CFG_W-1:0] h);
      int unsigned ew;
      int unsigned eh;
      int unsigned lim;
      ew = fit(w, LINE_MAX);
      eh = fit(h, apd_pkg::HEIGHT_MAX);
      if (row == 0 || row >= eh) lim = (col >= ew) ? 0 : col;
      else                       lim = ew;
      for (int i = 0; i < lim; i++) begin
        if (!line_seen[i]) return 0;
      end
      return 1;
    endfunction

    // called for every byte transfer on in
    function void take_residual(logic [apd_pkg::PIX_W-1:0] b);
      int unsigned               w;
      int unsigned               h;
      apd_pkg::pred_t            mode;
      logic [apd_pkg::PIX_W:0]   sum;
      logic [apd_pkg::PIX_W-1:0] v;
      pixel_t                    p;
      w = fit(width_reg, LINE_MAX);
      h = fit(height_reg, apd_pkg::HEIGHT_MAX);
      bytes_in++;
      if (pad_due) begin
        pad_due = 0;
        pads_in++;
        return;
      end
      // position kept across size changes, wrapped if now out of range
      if (row >= h) row = 0;
      if (col >= w) col = 0;
      if (row == 0 && col == 0) mode = apd_pkg::PRED_NONE;
      else if (row == 0)        mode = apd_pkg::PRED_LEFT;
      else if (col == 0)        mode = apd_pkg::PRED_UP;
      else                      mode = apd_pkg::PRED_AVG;
      case (mode)
        apd_pkg::PRED_NONE: v = b;
        apd_pkg::PRED_LEFT: v = left_px - b;
        apd_pkg::PRED_UP:   v = line_buf[0] - b;
        default: begin
          sum = {1'b0, left_px} + {1'b0, line_buf[col]};
          v   = sum[apd_pkg::PIX_W:1] - b;
        end
      endcase
      pred_hits[int'(mode)]++;
      line_buf[col]  = v;
      line_seen[col] = 1;
      left_px        = v;
      p.alpha     = v;
      p.row_end   = (col == w - 1);
      p.image_end = p.row_end && (row == h - 1);
      if (p.row_end) begin
        col     = 0;
        pad_due = w[0];
        row     = p.image_end ? 0 : row + 1;
      end else begin
        col++;
      end
      pixels_due.push_back(p);
    endfunction

    // called for every pixel transfer on out
    function void match_pixel(logic [apd_pkg::PIX_W-1:0] a, logic re, logic ie);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: pixel with nothing expected: alpha=%02h row_end=%0b image_end=%0b",
                 $time, a, re, ie);
        return;
      end
      want = pixels_due.pop_front();
      pixels_out++;
      if (want.image_end) images_out++;
      if (a !== want.alpha) begin
        errors++;
        $display("%0t: alpha_value expected %02h actual %02h", $time, want.alpha, a);
      end
      if (re !== want.row_end) begin
        errors++;
        $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, re);
      end
      if (ie !== want.image_end) begin
        errors++;
        $display("%0t: image_end expected %0b actual %0b", $time, want.image_end, ie);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  logic                          clk              = 1'b0;
  logic                          rst_n            = 1'b0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic [apd_pkg::PIX_W-1:0]     in_residual_byte = '0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic [apd_pkg::PIX_W-1:0]     out_alpha_value;
  logic                          out_row_end;
  logic                          out_image_end;
  logic                          psel             = 1'b0;
  logic                          penable          = 1'b0;
  logic                          pwrite           = 1'b0;
  logic [apd_pkg::PADDR_W-1:0]   paddr            = '0;
  logic [apd_pkg::PDATA_W-1:0]   pwdata           = '0;
  logic [apd_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  alpha_plane_tracker sb;

  always #5 clk = ~clk;

  alpha_predictive_decoder #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_residual_byte (in_residual_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_alpha_value  (out_alpha_value),
    .out_row_end      (out_row_end),
    .out_image_end    (out_image_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a pattern that is picked anew whenever its run
  // counter runs out, so stalls land on every phase of the sender's bursts.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rx_left[2];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: values are sampled at the edge, before the block updates.
  // The out check runs first so a byte transferred at the same edge can never
  // stand in for a missing expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.match_pixel(out_alpha_value, out_row_end, out_image_end);
      if (in_valid && in_ready)
        sb.take_residual(in_residual_byte);
    end
  end

  // ---------------------------------------------------------------------------
  // register port: setup cycle, access cycle, then idle
  task automatic reg_write(input logic [apd_pkg::PADDR_W-1:0] addr,
                           input logic [apd_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [apd_pkg::PADDR_W-1:0] addr,
                           input logic [apd_pkg::CFG_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[apd_pkg::CFG_W-1:0] !== want) begin
      sb.errors++;
      $display("%0t: register at %0h expected %0d actual %0d",
               $time, addr, want, prdata[apd_pkg::CFG_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write both size registers, sometimes with junk above bit 12, and read back
  task automatic program_size(input logic [apd_pkg::CFG_W-1:0] w,
                              input logic [apd_pkg::CFG_W-1:0] h);
    logic [apd_pkg::PDATA_W-1:0] junk_w;
    logic [apd_pkg::PDATA_W-1:0] junk_h;
    junk_w = ($urandom_range(0, 2) == 0) ? $urandom : '0;
    junk_h = ($urandom_range(0, 2) == 0) ? $urandom : '0;
    reg_write(apd_pkg::ADDR_IMAGE_WIDTH,  {junk_w[apd_pkg::PDATA_W-1:apd_pkg::CFG_W], w});
    reg_write(apd_pkg::ADDR_IMAGE_HEIGHT, {junk_h[apd_pkg::PDATA_W-1:apd_pkg::CFG_W], h});
    reg_check(apd_pkg::ADDR_IMAGE_WIDTH,  w);
    reg_check(apd_pkg::ADDR_IMAGE_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps. A zero gap keeps valid
  // high straight into the next burst; long bursts give idle-free stretches.
  task automatic send_stream(input byte_q_t data);
    int burst;
    int gap;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < data.size(); i++) begin
      in_valid         <= 1'b1;
      in_residual_byte <= data[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      burst--;
      if (burst == 0 && i < data.size() - 1) begin
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  // residual bytes with the extremes over-weighted
  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0:       q.push_back(8'h00);
        1:       q.push_back(8'hFF);
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    return q;
  endfunction

  // Sender holds off until every expected pixel is out, then gives a trailing
  // padding byte time to clear the two-stage pipe.
  task automatic wait_drained();
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    byte_q_t                   dq;
    logic [apd_pkg::CFG_W-1:0] nw;
    logic [apd_pkg::CFG_W-1:0] nh;
    int unsigned               ew;
    int unsigned               eh;
    int unsigned               per_row;
    int                        count;
    int                        sent;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of the size registers
    reg_check(apd_pkg::ADDR_IMAGE_WIDTH,  apd_pkg::IMAGE_WIDTH_RST);
    reg_check(apd_pkg::ADDR_IMAGE_HEIGHT, apd_pkg::IMAGE_HEIGHT_RST);

    // first pixel is the byte itself, then left minus byte along 640 x 480
    dq = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
           8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h00};
    send_stream(dq);
    wait_drained();

    // shrink mid-row: column restarts at 0 in the top row. A 3 x 3 image then
    // covers left, up and average prediction, row and image end, and the
    // padding byte after each odd-width row, the last one included.
    program_size(13'd3, 13'd3);
    dq = '{8'h10, 8'hFF, 8'h00, 8'h33,
           8'hFF, 8'h01, 8'h80, 8'hC3,
           8'h00, 8'hFF, 8'h7F, 8'h5A};
    send_stream(dq);
    wait_drained();

    // zero size reads as 1 x 1: every pixel starts and ends an image
    program_size(13'd0, 13'd0);
    send_stream(random_bytes(20));
    wait_drained();

    // all width bits set saturates to 4096; a partial top row of 64 pixels
    program_size(13'h1FFF, 13'd1);
    send_stream(random_bytes(64));
    wait_drained();

    // single column, height saturated, left open after 40 rows
    program_size(13'd1, 13'h1FFF);
    send_stream(random_bytes(80));
    wait_drained();

    // widen to the maximum below the top row; only columns the partial top
    // row wrote are read
    program_size(13'd4096, 13'd4096);
    send_stream(random_bytes(50));
    wait_drained();

    // row and column both out of range for a small size: back to the origin
    program_size(13'd6, 13'd2);

    // Random part: mostly whole small images, some stops mid-image followed
    // by a size change; large sizes only ever see partial rows.
    sent = 0;
    while (sent < RAND_BYTES) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:       nw = '0;
          1:       nw = apd_pkg::CFG_W'($urandom_range(0, 8191));
          2, 3:    nw = apd_pkg::CFG_W'($urandom_range(13, 80));
          default: nw = apd_pkg::CFG_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
          0:       nh = '0;
          1:       nh = apd_pkg::CFG_W'($urandom_range(0, 8191));
          2:       nh = apd_pkg::CFG_W'($urandom_range(7, 30));
          default: nh = apd_pkg::CFG_W'($urandom_range(1, 6));
        endcase
        if (sb.size_is_safe(nw, nh)) program_size(nw, nh);
      end
      ew      = sb.fit(sb.width_reg, LINE_MAX);
      eh      = sb.fit(sb.height_reg, apd_pkg::HEIGHT_MAX);
      per_row = ew + (ew & 1);
      if (per_row * eh <= 160 && $urandom_range(0, 3) != 0)
        count = per_row * eh * $urandom_range(1, 2);
      else
        count = $urandom_range(1, 60);
      send_stream(random_bytes(count));
      sent += count;
      wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("run: %0d residual bytes (%0d padding), %0d pixels, %0d complete images",
             sb.bytes_in, sb.pads_in, sb.pixels_out, sb.images_out);
    $display("predictors first/left/up/average: %0d/%0d/%0d/%0d; sizes 0, 1..80, 4096, 8191",
             sb.pred_hits[apd_pkg::PRED_NONE], sb.pred_hits[apd_pkg::PRED_LEFT],
             sb.pred_hits[apd_pkg::PRED_UP], sb.pred_hits[apd_pkg::PRED_AVG]);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
